/* rtl/core/iidl_pkg.sv */
// Package for the indexed insert/delete list: field widths, opcodes,
// status codes and the command struct shared by control and cells.
// No dependencies.
`default_nettype none

package iidl_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/iidl_cell.sv */
// One storage cell of the list: holds one entry, takes the new value
// or a neighbor's entry on insert or delete; read hit taps it out.
// Depends on iidl_pkg.
`default_nettype none

module iidl_cell import iidl_pkg::*; #(
  parameter int CMP_W = 8,
  parameter int IDX   = 0
) (
  input  wire logic                     clk,
  input  wire cmd_t                     cmd,
  input  wire logic [CMP_W-1:0]         pos,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic signed [DATA_W-1:0] lower_data,
  input  wire logic signed [DATA_W-1:0] upper_data,
  output logic signed [DATA_W-1:0]      data,
  output logic signed [DATA_W-1:0]      tap
);

  localparam logic [CMP_W-1:0] IDX_V = CMP_W'(IDX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     hit;
  logic                     above;

  assign hit   = (pos == IDX_V);
  assign above = (pos < IDX_V);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (hit) begin
        data_nxt = value;
      end else if (above) begin
        data_nxt = lower_data;
      end
    end else if (cmd.del) begin
      if (hit || above) begin
        data_nxt = upper_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign tap  = (cmd.rd && hit) ? data_r : '0;

endmodule

`default_nettype wire

/* rtl/core/iidl_ctrl.sv */
// Operation decode for the list: range and full checks, status code,
// next fill count and the command broadcast to the cell row.
// Depends on iidl_pkg.
`default_nettype none

module iidl_ctrl import iidl_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7,
  parameter int CMP_W    = 8
) (
  input  wire logic               go,
  input  wire logic [1:0]         opcode,
  input  wire logic [POS_W-1:0]   position,
  input  wire logic [CNT_W-1:0]   count,
  output cmd_t                    cmd,
  output status_t                 status,
  output logic [CNT_W-1:0]        count_nxt
);

  localparam logic [CMP_W-1:0] CAP_V = CMP_W'(CAPACITY);

  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] cnt_e;

  assign pos_e = CMP_W'(position);
  assign cnt_e = CMP_W'(count);

  always_comb begin
    cmd       = '0;
    status    = ST_OK;
    count_nxt = count;
    unique case (opcode)
      OP_INSERT: begin
        if (pos_e > cnt_e) begin
          status = ST_RANGE;
        end else if (cnt_e >= CAP_V) begin
          status = ST_FULL;
        end else begin
          cmd.ins   = go;
          count_nxt = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_e >= cnt_e) begin
          status = ST_RANGE;
        end else begin
          cmd.del   = go;
          count_nxt = count - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_e >= cnt_e) begin
          status = ST_RANGE;
        end else begin
          cmd.rd = go;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/indexed_insert_delete_list.sv */
// Indexed insert/delete list built as a row of shifting cells.
// An accepted transaction's status, read value and count are registered.
// One transaction per cycle unless a held result stalls the input;
// every shift, read and count update in the row uses the same edge.
// Reset clears the fill count and the result valid; cell contents stay
// undefined until written. Depends on iidl_pkg, iidl_ctrl, iidl_cell.
`default_nettype none

module indexed_insert_delete_list import iidl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_opcode,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic [COUNT_W-1:0]            out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic                     accept;
  cmd_t                     cmd;
  status_t                  status;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CMP_W-1:0]         pos_e;
  logic signed [DATA_W-1:0] data_w [CAPACITY];
  logic signed [DATA_W-1:0] tap_w  [CAPACITY];
  logic signed [DATA_W-1:0] rd_val;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic [COUNT_W-1:0]       out_count_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_e    = CMP_W'(in_position);

  iidl_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .CMP_W    (CMP_W)
  ) u_ctrl (
    .go        (accept),
    .opcode    (in_opcode),
    .position  (in_position),
    .count     (count_r),
    .cmd       (cmd),
    .status    (status),
    .count_nxt (count_nxt)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    if (i == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_low
      assign lower = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_up
      assign upper = data_w[i+1];
    end
    iidl_cell #(
      .CMP_W (CMP_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_e),
      .value      (in_value),
      .lower_data (lower),
      .upper_data (upper),
      .data       (data_w[i]),
      .tap        (tap_w[i])
    );
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | tap_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r     <= status;
      out_read_value_r <= rd_val;
      out_count_r      <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the count");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status below capacity");

  a_refused_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_read_value_r == '0)
    else $error("refused transaction carries read data");

endmodule

`default_nettype wire
